[hdl/radial_pair_force_core_assert.svh]
// ----------------------------------------------------------------------------
// Radial pair force assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RADIAL_PAIR_FORCE_CORE_ASSERT_SVH
`define RADIAL_PAIR_FORCE_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the trigger.
`define RPF_ASSERT_SAME(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// Consequence must hold in the cycle after the trigger.
`define RPF_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

[hdl/rpf_pkg.sv]
// ----------------------------------------------------------------------------
// Radial pair force package
// Number format, stage records, mode codes and arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpf_pkg;

    localparam int EXP_TABLE_BITS_DEF = 8;
    localparam int DIV_STEPS = 33;
    localparam int DIV_LAT = DIV_STEPS + 2;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [39:0] POS_MAX = 40'h7F_FFFF_FFFF;
    localparam logic [41:0] NEG_MAG = 42'h080_0000_0000;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_REPEL = 2'd1,
        MODE_LJ    = 2'd2,
        MODE_GAUSS = 2'd3
    } rpf_mode_t;

    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_LENGTH = 2'd1,
        CFG_ENERGY = 2'd2,
        CFG_UNUSED = 2'd3
    } rpf_cfg_t;

    // Value is m * 2^e, m zero or normalized to [2^31, 2^32).
    typedef struct packed {
        logic [31:0]        m;
        logic signed [11:0] e;
    } rpf_num_t;

    typedef struct packed {
        logic      valid;
        rpf_mode_t mode;
        logic      dzero;
    } rpf_side_t;

    typedef struct packed {
        logic        valid;
        rpf_mode_t   mode;
        logic        dzero;
        logic        tail;
        logic        neg;
        rpf_num_t    r;
        rpf_num_t    es;
        rpf_num_t    p;
        rpf_num_t    h;
        logic [41:0] mag;
    } rpf_stage_t;

    localparam rpf_num_t LOG2E_NUM = '{m: 32'd94548 << 15, e: -12'sd31};
    localparam rpf_num_t C24_NUM   = '{m: 32'hC000_0000, e: -12'sd27};
    localparam rpf_num_t C12_NUM   = '{m: 32'hC000_0000, e: -12'sd28};

    function automatic logic [4:0] lzc24(input logic [23:0] a);
        logic [4:0] cnt;
        cnt = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (a[i])
                cnt = 5'(23 - i);
        end
        return cnt;
    endfunction

    function automatic rpf_num_t mul(input rpf_num_t a, input rpf_num_t b);
        logic [63:0] prod;
        rpf_num_t    r;
        prod = 64'(a.m) * 64'(b.m);
        if (a.m == 32'd0 || b.m == 32'd0) begin
            r.m = 32'd0;
            r.e = 12'sd0;
        end else if (prod[63]) begin
            r.m = prod[63:32];
            r.e = a.e + b.e + 12'sd32;
        end else begin
            r.m = prod[62:31];
            r.e = a.e + b.e + 12'sd31;
        end
        return r;
    endfunction

    // Truncated value * 2^frac; bit 41 alone marks a value that is too large.
    function automatic logic [41:0] to_fixed(input rpf_num_t a, input logic [5:0] frac);
        logic signed [12:0] sh;
        logic [41:0]        v;
        logic [5:0]         nsh;
        sh  = {a.e[11], a.e} + 13'(frac);
        nsh = 6'(-sh);
        if (a.m == 32'd0)
            v = 42'd0;
        else if (sh >= 13'sd9)
            v = 42'd1 << 41;
        else if (sh >= 13'sd0)
            v = {10'd0, a.m} << sh[3:0];
        else if (sh <= -13'sd32)
            v = 42'd0;
        else
            v = {10'd0, a.m >> nsh[4:0]};
        return v;
    endfunction

    // Table entry 2^(-k/2^bits) in Q32 by a Taylor series through the twelfth-order term.
    function automatic logic [32:0] exp_entry(input int k, input int bits);
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] s;
        a = (64'(k) * 64'(LN2_Q32)) >> bits;
        t = 64'd1 << 32;
        s = 64'd1 << 32;
        for (int n = 1; n <= 12; n++) begin
            t = ((t * a) >> 32) / 64'(n);
            if (n % 2 == 1)
                s = s - t;
            else
                s = s + t;
        end
        return s[32:0];
    endfunction

endpackage

[hdl/radial_pair_force_core.sv]
// ----------------------------------------------------------------------------
// Radial pair force core
// Signed radial force of a pair potential, one distance word per cycle unless stalled.
// ----------------------------------------------------------------------------
//  channel   valid         stall         payload
//  input     pair_valid    pair_stall    distance
//  output    force_valid   force_stall   force_res, saturated
//  config    cfg_we        -             cfg_index, cfg_data
//
// One word enters per cycle while the output is not stalled. A word passes 35
// pipelined divider stages (normalizing, one quotient bit per step, normalizing)
// and 8 multiply stages plus the output register. A stalled output word freezes
// the whole pipeline and raises pair_stall; nothing is dropped or repeated.
// Reset clears all valid bits and loads mode none with unit length and energy scales.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radial_pair_force_core_assert.svh"

module radial_pair_force_core #(
    parameter int EXP_TABLE_BITS = rpf_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pair_valid,
    output logic               pair_stall,
    input  logic [23:0]        distance,
    output logic               force_valid,
    input  logic               force_stall,
    output logic signed [39:0] force_res,
    output logic               saturated,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    localparam int LAT = rpf_pkg::DIV_LAT;

    rpf_pkg::rpf_mode_t  mode_reg;
    logic [23:0]         scale_reg;
    logic [23:0]         energy_reg;
    logic [23:0]         scale_eff;

    logic                en;
    rpf_pkg::rpf_side_t  side_reg [LAT];

    logic [23:0]         q_num;
    logic [23:0]         q_den;
    rpf_pkg::rpf_num_t   q_ratio;
    rpf_pkg::rpf_num_t   es_ratio;

    rpf_pkg::rpf_stage_t chain_in;
    rpf_pkg::rpf_stage_t chain_last;

    logic                out_valid_reg;
    logic [39:0]         force_reg;
    logic [39:0]         force_next;
    logic                sat_reg;
    logic                sat_next;
    rpf_pkg::rpf_mode_t  out_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= rpf_pkg::MODE_NONE;
            scale_reg  <= 24'd65536;
            energy_reg <= 24'd65536;
        end
        else if (cfg_we)
        begin
            case (rpf_pkg::rpf_cfg_t'(cfg_index))
                rpf_pkg::CFG_MODE:   mode_reg   <= rpf_pkg::rpf_mode_t'(cfg_data[1:0]);
                rpf_pkg::CFG_LENGTH: scale_reg  <= cfg_data;
                rpf_pkg::CFG_ENERGY: energy_reg <= cfg_data;
                default:             mode_reg   <= mode_reg;
            endcase
        end
    end

    assign en         = !(out_valid_reg && force_stall);
    assign pair_stall = !en;
    assign scale_eff  = (scale_reg == 24'd0) ? 24'd1 : scale_reg;

    // The Gaussian core needs r/s, the power laws need s/r.
    assign q_num = (mode_reg == rpf_pkg::MODE_GAUSS) ? distance : scale_eff;
    assign q_den = (mode_reg == rpf_pkg::MODE_GAUSS) ? scale_eff : distance;

    rpf_ratio u_ratio_q (
        .clk   (clk),
        .en    (en),
        .num   (q_num),
        .den   (q_den),
        .ratio (q_ratio)
    );

    rpf_ratio u_ratio_es (
        .clk   (clk),
        .en    (en),
        .num   (energy_reg),
        .den   (scale_eff),
        .ratio (es_ratio)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < LAT; j++)
                side_reg[j] <= '0;
        end
        else if (en)
        begin
            side_reg[0].valid <= pair_valid;
            side_reg[0].mode  <= mode_reg;
            side_reg[0].dzero <= (distance == 24'd0);
            for (int j = 1; j < LAT; j++)
                side_reg[j] <= side_reg[j-1];
        end
    end

    always_comb
    begin
        chain_in       = '0;
        chain_in.valid = side_reg[LAT-1].valid;
        chain_in.mode  = side_reg[LAT-1].mode;
        chain_in.dzero = side_reg[LAT-1].dzero;
        chain_in.r     = q_ratio;
        chain_in.es    = es_ratio;
    end

    rpf_mulchain #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_mulchain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .stage_in  (chain_in),
        .stage_out (chain_last)
    );

    always_comb
    begin
        logic [41:0] mag;
        logic        neg;
        mag        = rpf_pkg::to_fixed(chain_last.p, 6'd16);
        neg        = chain_last.neg && (chain_last.mode == rpf_pkg::MODE_LJ);
        force_next = 40'd0;
        sat_next   = 1'b0;
        if (chain_last.mode == rpf_pkg::MODE_NONE) begin
            force_next = 40'd0;
        end else if (chain_last.mode == rpf_pkg::MODE_GAUSS && chain_last.tail) begin
            force_next = 40'd0;
        end else if (chain_last.mode != rpf_pkg::MODE_GAUSS && chain_last.dzero) begin
            force_next = rpf_pkg::POS_MAX;
            sat_next   = 1'b1;
        end else if (!neg) begin
            if (mag > {2'b00, rpf_pkg::POS_MAX}) begin
                force_next = rpf_pkg::POS_MAX;
                sat_next   = 1'b1;
            end else begin
                force_next = mag[39:0];
            end
        end else begin
            if (mag > rpf_pkg::NEG_MAG) begin
                force_next = 40'(42'd0 - rpf_pkg::NEG_MAG);
                sat_next   = 1'b1;
            end else begin
                force_next = 40'(42'd0 - mag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            force_reg     <= 40'd0;
            sat_reg       <= 1'b0;
            out_mode_reg  <= rpf_pkg::MODE_NONE;
        end
        else if (en)
        begin
            out_valid_reg <= chain_last.valid;
            force_reg     <= force_next;
            sat_reg       <= sat_next;
            out_mode_reg  <= chain_last.mode;
        end
    end

    assign force_valid = out_valid_reg;
    assign force_res   = signed'(force_reg);
    assign saturated   = sat_reg;

    `RPF_ASSERT_SAME(a_sat_at_limit, out_valid_reg && sat_reg,
        force_reg == rpf_pkg::POS_MAX || force_reg == 40'h80_0000_0000,
        "saturated word is not at a range limit")
    `RPF_ASSERT_SAME(a_none_is_zero, out_valid_reg && out_mode_reg == rpf_pkg::MODE_NONE,
        force_reg == 40'd0 && !sat_reg, "mode none gave a nonzero force")
    `RPF_ASSERT_SAME(a_neg_only_lj, out_valid_reg && force_reg[39],
        out_mode_reg == rpf_pkg::MODE_LJ, "negative force outside Lennard-Jones mode")
    `RPF_ASSERT_NEXT(a_chain_frozen, !en, $stable(chain_last),
        "multiply chain moved while the output was stalled")

endmodule

[hdl/rpf_ratio.sv]
// ----------------------------------------------------------------------------
// Radial pair force ratio unit
// Pipelined restoring divider giving num/den as a normalized number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpf_ratio (
    input  logic              clk,
    input  logic              en,
    input  logic [23:0]       num,
    input  logic [23:0]       den,
    output rpf_pkg::rpf_num_t ratio
);

    localparam int N = rpf_pkg::DIV_STEPS;

    logic [23:0]        rem_reg  [N+1];
    logic [32:0]        quo_reg  [N+1];
    logic [23:0]        den_reg  [N+1];
    logic signed [11:0] exp_reg  [N+1];
    logic               zero_reg [N+1];

    logic [23:0]        rem_next [N+1];
    logic [32:0]        quo_next [N+1];

    logic [4:0]         num_lz;
    logic [4:0]         den_lz;
    logic [23:0]        den_safe;

    rpf_pkg::rpf_num_t  ratio_next;
    rpf_pkg::rpf_num_t  ratio_reg;

    // Both operands are normalized so every step is one narrow compare.
    assign den_safe = (den == 24'd0) ? 24'd1 : den;
    assign num_lz   = rpf_pkg::lzc24(num);
    assign den_lz   = rpf_pkg::lzc24(den_safe);

    always_comb
    begin
        logic [24:0] trial;
        logic        qbit;
        rem_next[0] = num << num_lz;
        quo_next[0] = 33'd0;
        for (int j = 1; j <= N; j++) begin
            if (j == 1)
                trial = {1'b0, rem_reg[0]};
            else
                trial = {rem_reg[j-1], 1'b0};
            qbit = (trial >= {1'b0, den_reg[j-1]});
            if (qbit)
                rem_next[j] = 24'(trial - {1'b0, den_reg[j-1]});
            else
                rem_next[j] = trial[23:0];
            quo_next[j] = {quo_reg[j-1][31:0], qbit};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            quo_reg[0]  <= quo_next[0];
            den_reg[0]  <= den_safe << den_lz;
            exp_reg[0]  <= 12'(signed'({7'd0, den_lz})) - 12'(signed'({7'd0, num_lz}))
                           - 12'sd32;
            zero_reg[0] <= (num == 24'd0);
            for (int j = 1; j <= N; j++) begin
                rem_reg[j]  <= rem_next[j];
                quo_reg[j]  <= quo_next[j];
                den_reg[j]  <= den_reg[j-1];
                exp_reg[j]  <= exp_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
            end
            ratio_reg <= ratio_next;
        end
    end

    // Low bits below 2^-40 are cleared, matching a quotient taken at that scale.
    always_comb
    begin
        logic [32:0]        q;
        logic signed [11:0] e;
        logic [31:0]        m;
        logic [4:0]         z;
        q = quo_reg[N];
        if (q[32]) begin
            m = q[32:1];
            e = exp_reg[N] + 12'sd1;
        end else begin
            m = q[31:0];
            e = exp_reg[N];
        end
        z = (e < -12'sd40) ? 5'(-12'sd40 - e) : 5'd0;
        m = m & (32'hFFFF_FFFF << z);
        if (zero_reg[N]) begin
            ratio_next.m = 32'd0;
            ratio_next.e = 12'sd0;
        end else begin
            ratio_next.m = m;
            ratio_next.e = e;
        end
    end

    assign ratio = ratio_reg;

endmodule

[hdl/rpf_mulchain.sv]
// ----------------------------------------------------------------------------
// Radial pair force multiply chain
// Eight registered stages, at most one product per word in each, forming the force.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpf_mulchain #(
    parameter int EXP_TABLE_BITS = rpf_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  rpf_pkg::rpf_stage_t stage_in,
    output rpf_pkg::rpf_stage_t stage_out
);

    localparam int TBL_SIZE = 2 ** EXP_TABLE_BITS;

    rpf_pkg::rpf_stage_t s_reg  [1:8];
    rpf_pkg::rpf_stage_t s_next [1:8];

    logic [32:0] exp_tbl [TBL_SIZE];

    logic [41:0]                 yq;
    logic [5:0]                  yn;
    logic [EXP_TABLE_BITS-1:0]   yk;
    logic [32:0]                 tv;
    logic [41:0]                 c6;
    logic [5:0]                  lead;

    for (genvar g = 0; g < TBL_SIZE; g++) begin : gen_tbl
        localparam logic [32:0] ENTRY = rpf_pkg::exp_entry(g, EXP_TABLE_BITS);
        assign exp_tbl[g] = ENTRY;
    end

    assign yq = rpf_pkg::to_fixed(s_reg[2].p, 6'd16);
    assign yn = yq[21:16];
    assign yk = yq[15 -: EXP_TABLE_BITS];
    assign tv = exp_tbl[yk];
    assign c6 = rpf_pkg::to_fixed(s_reg[4].h, 6'd33);

    always_comb
    begin
        lead = 6'd0;
        for (int i = 0; i < 42; i++) begin
            if (s_reg[5].mag[i])
                lead = 6'(i);
        end
    end

    always_comb
    begin
        // Squares and cubes of the ratio, or the scaled exponent argument.
        s_next[1]   = stage_in;
        s_next[1].p = rpf_pkg::mul(stage_in.r, stage_in.r);

        s_next[2] = s_reg[1];
        if (s_reg[1].mode == rpf_pkg::MODE_GAUSS)
            s_next[2].p = rpf_pkg::mul(s_reg[1].p, rpf_pkg::LOG2E_NUM);
        else
            s_next[2].p = rpf_pkg::mul(s_reg[1].p, s_reg[1].r);

        s_next[3] = s_reg[2];
        if (s_reg[2].mode == rpf_pkg::MODE_GAUSS) begin
            s_next[3].tail = (yq[41:22] != 20'd0);
            if (tv[32]) begin
                s_next[3].h.m = 32'h8000_0000;
                s_next[3].h.e = -12'sd31 - 12'(signed'({6'd0, yn}));
            end else begin
                s_next[3].h.m = tv[31:0];
                s_next[3].h.e = -12'sd32 - 12'(signed'({6'd0, yn}));
            end
            s_next[3].p.m = s_reg[2].r.m;
            s_next[3].p.e = s_reg[2].r.e + 12'sd1;
        end else begin
            s_next[3].p = rpf_pkg::mul(s_reg[2].p, s_reg[2].p);
        end

        s_next[4] = s_reg[3];
        if (s_reg[3].mode == rpf_pkg::MODE_GAUSS) begin
            s_next[4].p = rpf_pkg::mul(s_reg[3].p, s_reg[3].h);
        end else begin
            s_next[4].h = s_reg[3].p;
            s_next[4].p = rpf_pkg::mul(s_reg[3].p, s_reg[3].r);
        end

        // The attractive term sign comes from 2*q^6 - 1 in Q32.
        s_next[5] = s_reg[4];
        case (s_reg[4].mode)
            rpf_pkg::MODE_REPEL:
                s_next[5].p = rpf_pkg::mul(s_reg[4].h, s_reg[4].p);
            rpf_pkg::MODE_LJ:
            begin
                s_next[5].p = rpf_pkg::mul(rpf_pkg::C24_NUM, s_reg[4].p);
                if (c6 >= (42'd1 << 32)) begin
                    s_next[5].neg = 1'b0;
                    s_next[5].mag = c6 - (42'd1 << 32);
                end else begin
                    s_next[5].neg = 1'b1;
                    s_next[5].mag = (42'd1 << 32) - c6;
                end
            end
            rpf_pkg::MODE_GAUSS:
                s_next[5].p = rpf_pkg::mul(s_reg[4].p, s_reg[4].es);
            default:
                s_next[5].p = s_reg[4].p;
        endcase

        s_next[6] = s_reg[5];
        case (s_reg[5].mode)
            rpf_pkg::MODE_REPEL:
                s_next[6].p = rpf_pkg::mul(rpf_pkg::C12_NUM, s_reg[5].p);
            rpf_pkg::MODE_LJ:
            begin
                if (s_reg[5].mag == 42'd0) begin
                    s_next[6].h.m = 32'd0;
                    s_next[6].h.e = 12'sd0;
                end else begin
                    if (lead >= 6'd31)
                        s_next[6].h.m = 32'(s_reg[5].mag >> (lead - 6'd31));
                    else
                        s_next[6].h.m = 32'(s_reg[5].mag << (6'd31 - lead));
                    s_next[6].h.e = 12'(signed'({6'd0, lead})) - 12'sd63;
                end
            end
            default:
                s_next[6].p = s_reg[5].p;
        endcase

        s_next[7] = s_reg[6];
        if (s_reg[6].mode == rpf_pkg::MODE_LJ)
            s_next[7].p = rpf_pkg::mul(s_reg[6].p, s_reg[6].h);

        s_next[8] = s_reg[7];
        if (s_reg[7].mode == rpf_pkg::MODE_LJ)
            s_next[8].p = rpf_pkg::mul(s_reg[7].p, s_reg[7].es);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 1; j <= 8; j++)
                s_reg[j] <= '0;
        end
        else if (en)
        begin
            for (int j = 1; j <= 8; j++)
                s_reg[j] <= s_next[j];
        end
    end

    assign stage_out = s_reg[8];

endmodule
